// ----- rtl/core/dhcp_os_pkg.sv -----
// dhcp_os_pkg: types, constants and the cookie table for the DHCP option scanner.
// Used by dhcp_os_parser, dhcp_os_outreg and dhcp_option_scanner_top; no dependencies.
`default_nettype none

package dhcp_os_pkg;

    localparam int HEADER_BYTES    = 236;
    localparam int MAX_VALUE_BYTES = 8;
    localparam int VALUE_BYTES     = 8;

    localparam int POS_W = $clog2(HEADER_BYTES + 5);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int LIMIT_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_LIMIT = 1'b1;

    localparam logic [7:0]         WANTED_CODE_RST = 8'd53;
    localparam logic [LIMIT_W-1:0] VALUE_LIMIT_RST = 4'd4;

    localparam logic [7:0] CODE_PAD = 8'd0;
    localparam logic [7:0] CODE_END = 8'd255;

    localparam logic [2:0] ST_NOT_FOUND  = 3'd0;
    localparam logic [2:0] ST_FOUND      = 3'd1;
    localparam logic [2:0] ST_BAD_COOKIE = 3'd2;
    localparam logic [2:0] ST_OVERRUN    = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;

    localparam int RES_W   = 3 + 8 + 8 * VALUE_BYTES;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic [8*VALUE_BYTES-1:0] value;
        logic [7:0]               length;
        logic [2:0]               status;
    } res_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd99;
            2'd1:    b = 8'd130;
            2'd2:    b = 8'd83;
            2'd3:    b = 8'd99;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dhcp_os_parser.sv -----
// dhcp_os_parser: per-byte header skip, cookie check and option walk with capture.
// Holds the configuration registers; depends on dhcp_os_pkg.
`default_nettype none

module dhcp_os_parser (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [dhcp_os_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dhcp_os_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                                 in_accept,
    input  wire logic [7:0]                           msg_byte,
    input  wire logic                                 last_byte,
    output logic                                      res_valid,
    output dhcp_os_pkg::res_t                         res
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_COOKIE,
        PH_CODE,
        PH_LEN,
        PH_VALUE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam int PW = dhcp_os_pkg::POS_W;
    localparam int VW = 8 * dhcp_os_pkg::VALUE_BYTES;
    localparam int LW = dhcp_os_pkg::LIMIT_W;

    logic [7:0]    wanted_code_reg;
    logic [LW-1:0] value_limit_reg;

    phase_t        phase_reg, phase_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    code_reg, code_next;
    logic [7:0]    left_reg, left_next;
    logic [VW-1:0] value_reg, value_next;
    logic [7:0]    length_reg, length_next;
    logic [2:0]    verdict_reg, verdict_next;

    logic [LW-1:0] lim;
    logic [1:0]    cookie_idx;
    logic [2:0]    lane;
    logic [7:0]    left_dec;

    always_comb begin
        lim = (value_limit_reg > LW'(dhcp_os_pkg::MAX_VALUE_BYTES))
            ? LW'(dhcp_os_pkg::MAX_VALUE_BYTES) : value_limit_reg;
        cookie_idx = 2'(pos_reg - PW'(dhcp_os_pkg::HEADER_BYTES));
        lane       = 3'(length_reg - left_reg);
        left_dec   = left_reg - 8'd1;

        phase_next   = phase_reg;
        pos_next     = pos_reg;
        code_next    = code_reg;
        left_next    = left_reg;
        value_next   = value_reg;
        length_next  = length_reg;
        verdict_next = verdict_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (in_accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    pos_next = pos_reg + PW'(1);
                    if (pos_next >= PW'(dhcp_os_pkg::HEADER_BYTES)) begin
                        phase_next = PH_COOKIE;
                    end
                end
                PH_COOKIE: begin
                    pos_next = pos_reg + PW'(1);
                    if (msg_byte != dhcp_os_pkg::cookie_byte(cookie_idx)) begin
                        verdict_next = dhcp_os_pkg::ST_BAD_COOKIE;
                        phase_next   = PH_DONE;
                    end else if (cookie_idx == 2'd3) begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (msg_byte == dhcp_os_pkg::CODE_END) begin
                        verdict_next = dhcp_os_pkg::ST_NOT_FOUND;
                        phase_next   = PH_DONE;
                    end else if (msg_byte != dhcp_os_pkg::CODE_PAD) begin
                        code_next  = msg_byte;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN: begin
                    left_next = msg_byte;
                    if (code_reg == wanted_code_reg) begin
                        length_next = msg_byte;
                        value_next  = '0;
                        if (msg_byte == 8'd0) begin
                            verdict_next = dhcp_os_pkg::ST_FOUND;
                            phase_next   = PH_DONE;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end else begin
                        phase_next = (msg_byte == 8'd0) ? PH_CODE : PH_SKIP;
                    end
                end
                PH_VALUE: begin
                    if (length_reg <= 8'(lim)) begin
                        for (int i = 0; i < dhcp_os_pkg::VALUE_BYTES; i++) begin
                            if (lane == 3'(i)) begin
                                value_next[VW-8-8*i +: 8] = value_reg[VW-8-8*i +: 8] | msg_byte;
                            end
                        end
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        verdict_next = (length_reg > 8'(lim))
                            ? dhcp_os_pkg::ST_TOO_LONG : dhcp_os_pkg::ST_FOUND;
                        phase_next = PH_DONE;
                    end
                end
                PH_SKIP: begin
                    left_next = left_dec;
                    if (left_dec == 8'd0) begin
                        phase_next = PH_CODE;
                    end
                end
                default: begin
                end
            endcase

            if (last_byte) begin
                res_valid = 1'b1;
                case (phase_next)
                    PH_HEADER, PH_COOKIE: res.status = dhcp_os_pkg::ST_BAD_COOKIE;
                    PH_CODE:              res.status = dhcp_os_pkg::ST_NOT_FOUND;
                    PH_LEN, PH_VALUE, PH_SKIP: res.status = dhcp_os_pkg::ST_OVERRUN;
                    default:              res.status = verdict_next;
                endcase
                if (res.status == dhcp_os_pkg::ST_FOUND) begin
                    res.length = length_next;
                    res.value  = value_next;
                end
                phase_next   = PH_HEADER;
                pos_next     = '0;
                code_next    = '0;
                left_next    = '0;
                value_next   = '0;
                length_next  = '0;
                verdict_next = dhcp_os_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_code_reg <= dhcp_os_pkg::WANTED_CODE_RST;
            value_limit_reg <= dhcp_os_pkg::VALUE_LIMIT_RST;
            phase_reg       <= PH_HEADER;
            pos_reg         <= '0;
            code_reg        <= '0;
            left_reg        <= '0;
            value_reg       <= '0;
            length_reg      <= '0;
            verdict_reg     <= dhcp_os_pkg::ST_NOT_FOUND;
        end else begin
            if (cfg_we && cfg_index == dhcp_os_pkg::CFG_WANTED_CODE) begin
                wanted_code_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == dhcp_os_pkg::CFG_VALUE_LIMIT) begin
                value_limit_reg <= cfg_wdata[LW-1:0];
            end
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            code_reg    <= code_next;
            left_reg    <= left_next;
            value_reg   <= value_next;
            length_reg  <= length_next;
            verdict_reg <= verdict_next;
        end
    end

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |=> (phase_reg == PH_HEADER && pos_reg == '0))
        else $error("scan state not cleared after result");

    a_header_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HEADER) |-> (pos_reg < PW'(dhcp_os_pkg::HEADER_BYTES)))
        else $error("header position past header");

    a_value_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_VALUE) |-> (left_reg != 8'd0 && left_reg <= length_reg))
        else $error("value byte count out of range");

endmodule

`default_nettype wire

// ----- rtl/core/dhcp_os_outreg.sv -----
// dhcp_os_outreg: result register with a skid stage toward the result channel.
// Depends on dhcp_os_pkg for the result type.
`default_nettype none

module dhcp_os_outreg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire dhcp_os_pkg::res_t push_data,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dhcp_os_pkg::res_t      out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    dhcp_os_pkg::res_t out_data_reg, out_data_next;
    dhcp_os_pkg::res_t skid_data_reg, skid_data_next;
    logic              pop;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pop       = out_valid_reg && out_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
        if (push) begin
            if (!out_valid_reg || (pop && !skid_valid_reg)) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a request while output is empty");

    a_skid_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid request not moved to output");

    a_direct_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("request into empty stage went to skid");

endmodule

`default_nettype wire

// ----- rtl/core/dhcp_option_scanner_top.sv -----
// dhcp_option_scanner_top: streaming DHCP option scanner, top level.
// Instantiates dhcp_os_parser and dhcp_os_outreg; depends on dhcp_os_pkg.
//
// Usage:
//   The input stream carries one message byte per request on s_tdata[7:0],
//   starting at the DHCP payload, with s_tlast on the final byte. The scanner
//   skips the fixed header, checks the magic cookie and walks the options,
//   capturing the first option whose code matches wanted_code.
//   One request leaves on the m_ side for each byte that carries s_tlast;
//   other bytes produce nothing.
//   Throughput is one byte per cycle while s_tready is high; the result is
//   registered in dhcp_os_outreg as the last byte is taken.
//   When the receiver stalls, one result is held in the output register and a
//   second in the skid stage; bytes keep flowing until the skid stage fills,
//   then s_tready drops until the receiver takes the waiting request.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect on the
//   next edge; write only while no message is in progress.
//   Synchronous reset (aresetn low) clears the scan, empties the output and
//   restores wanted_code 53 and value_limit 4.
`default_nettype none

module dhcp_option_scanner_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_we,
    input  wire logic [dhcp_os_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dhcp_os_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,   // msg_byte
    input  wire logic                                 s_tlast,   // last_byte
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // scan_status [2:0], found_length [10:3], found_value [74:11], zero [79:75]
    output logic [dhcp_os_pkg::TDATA_W-1:0]           m_tdata
);

    logic              accept;
    logic              res_valid;
    dhcp_os_pkg::res_t res;
    dhcp_os_pkg::res_t out_res;

    assign accept = s_tvalid && s_tready;

    dhcp_os_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_accept (accept),
        .msg_byte  (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    dhcp_os_outreg u_outreg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = dhcp_os_pkg::TDATA_W'(out_res);

endmodule

`default_nettype wire
